FILE: rtl/core/tss_pkg.sv
// Shared types and constants for the two-stacks-in-one-memory block.
// Depends on nothing; every other file in rtl/core but tss_ram imports it.
package tss_pkg;

   // Storage geometry
   localparam int DEPTH       = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W       = $clog2(DEPTH + 1);

   // Fixed field widths of the ports
   localparam int OP_W        = 3;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int SIZE_W      = 7;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [CNT_W-1:0]      count_type;

   // Size after reset; DEPTH never exceeds the 7-bit register range
   localparam count_type SIZE_RESET = CNT_W'(DEPTH);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_ONE = 3'd0,
      OP_PUSH_TWO = 3'd1,
      OP_POP_ONE  = 3'd2,
      OP_POP_TWO  = 3'd3,
      OP_LIST_ONE = 3'd4,
      OP_LIST_TWO = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2
   } status_type;

   // What the back end has to do with one item
   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_READ,
      CMD_LIST,
      CMD_ERROR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      status_type   status;
      addr_type     addr;
      count_type    len;
      logic         down;
      word_type     data;
   } cmd_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_LIST
   } back_state_type;

endpackage

FILE: rtl/core/two_stacks_shared_memory.sv
// Top level of the two-stacks-in-one-memory block.
// Depends on tss_pkg, tss_front, tss_queue and tss_back (which holds tss_ram).
//
// Usage:
//   Input channel: an item (req_op, req_push_value) is taken at a rising edge
//   with start high and busy low. Ops: push one, push two, pop one, pop two,
//   list one, list two; codes 6 and 7 are dropped with no result.
//   Result channel: each result shows on rsp_status, rsp_data_out and
//   rsp_last for one cycle with rsp_strobe high; the receiver cannot stall.
//   Push, pop and error items give one result; a list of k words gives k
//   results, rsp_last marking the final one.
//   With the back end free, an item passes the command queue and then the
//   response register before rsp_strobe rises; items queued behind a list
//   wait for it. Throughput: one push, pop or error item per cycle while no
//   list holds the back end, which reads listed words one by one through the
//   single RAM read port. busy rises when the two-entry command queue is full.
//   Configuration: csr_wr_en writes the size in use (saturated to the memory
//   depth) and empties both stacks; write only while the block is idle.
//   Reset: size returns to the full depth and both stacks are empty; there
//   is no clearing pass over the memory.
module two_stacks_shared_memory (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [tss_pkg::OP_W-1:0]           req_op,
   input  logic signed [tss_pkg::VALUE_W-1:0] req_push_value,
   output logic                               rsp_strobe,
   output logic [tss_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [tss_pkg::VALUE_W-1:0] rsp_data_out,
   output logic                               rsp_last,
   input  logic                               csr_wr_en,
   input  logic [tss_pkg::SIZE_W-1:0]         csr_wr_data
);
   import tss_pkg::*;

   logic    accept;
   logic    cmd_push;
   cmd_type cmd;
   logic    cmd_pop;
   logic    cmd_valid;
   logic    queue_full;
   cmd_type head;

   assign busy   = queue_full;
   assign accept = start & ~queue_full;

   // Front: classify items, own the stack counts
   tss_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_op         (req_op),
      .req_push_value (req_push_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd_push       (cmd_push),
      .cmd            (cmd)
   );

   // Command queue
   tss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (cmd),
      .pop       (cmd_pop),
      .not_empty (cmd_valid),
      .full      (queue_full),
      .head      (head)
   );

   // Back: memory accesses and results
   tss_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .head         (head),
      .cmd_pop      (cmd_pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_last     (rsp_last)
   );

endmodule

FILE: rtl/core/tss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; the width and depth come from its parameters.
module tss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/tss_queue.sv
// Short command queue between the front and back ends.
// Depends on tss_pkg for the command type and queue depth.
module tss_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tss_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             not_empty,
   output logic             full,
   output tss_pkg::cmd_type head
);
   import tss_pkg::*;

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head      = slot_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/core/tss_front.sv
// Front end: size register, stack counts and classification of each item.
// Depends on tss_pkg; feeds classified commands into tss_queue.
module tss_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [tss_pkg::OP_W-1:0]      req_op,
   input  logic signed [tss_pkg::VALUE_W-1:0] req_push_value,
   input  logic                          csr_wr_en,
   input  logic [tss_pkg::SIZE_W-1:0]    csr_wr_data,
   output logic                          cmd_push,
   output tss_pkg::cmd_type              cmd
);
   import tss_pkg::*;

   count_type size_ff, size_in;
   count_type count_one_ff, count_one_in;
   count_type count_two_ff, count_two_in;
   logic [CNT_W:0] used;
   logic           room;

   assign used = {1'b0, count_one_ff} + {1'b0, count_two_ff};
   assign room = (used < {1'b0, size_ff});

   // Classify the item and update the stack counts
   always_comb begin
      size_in      = size_ff;
      count_one_in = count_one_ff;
      count_two_in = count_two_ff;
      cmd_push     = 1'b0;
      cmd.kind     = CMD_ERROR;
      cmd.status   = ST_OK;
      cmd.addr     = '0;
      cmd.len      = '0;
      cmd.down     = 1'b0;
      cmd.data     = word_type'(req_push_value);

      if (csr_wr_en) begin
         // A size write saturates to the memory depth and empties both stacks
         size_in      = (csr_wr_data > SIZE_W'(DEPTH)) ? SIZE_RESET : CNT_W'(csr_wr_data);
         count_one_in = '0;
         count_two_in = '0;
      end else if (accept) begin
         unique case (req_op)
            OP_PUSH_ONE: begin
               cmd_push = 1'b1;
               if (room) begin
                  cmd.kind     = CMD_WRITE;
                  cmd.addr     = ADDR_W'(count_one_ff);
                  count_one_in = count_one_ff + CNT_W'(1);
               end else begin
                  cmd.status = ST_OVERFLOW;
               end
            end
            OP_PUSH_TWO: begin
               cmd_push = 1'b1;
               if (room) begin
                  cmd.kind     = CMD_WRITE;
                  cmd.addr     = ADDR_W'(size_ff - count_two_ff - CNT_W'(1));
                  count_two_in = count_two_ff + CNT_W'(1);
               end else begin
                  cmd.status = ST_OVERFLOW;
               end
            end
            OP_POP_ONE: begin
               cmd_push = 1'b1;
               if (count_one_ff != '0) begin
                  cmd.kind     = CMD_READ;
                  cmd.addr     = ADDR_W'(count_one_ff - CNT_W'(1));
                  count_one_in = count_one_ff - CNT_W'(1);
               end else begin
                  cmd.status = ST_EMPTY;
               end
            end
            OP_POP_TWO: begin
               cmd_push = 1'b1;
               if (count_two_ff != '0) begin
                  cmd.kind     = CMD_READ;
                  cmd.addr     = ADDR_W'(size_ff - count_two_ff);
                  count_two_in = count_two_ff - CNT_W'(1);
               end else begin
                  cmd.status = ST_EMPTY;
               end
            end
            OP_LIST_ONE: begin
               cmd_push = 1'b1;
               if (count_one_ff != '0) begin
                  cmd.kind = CMD_LIST;
                  cmd.addr = '0;
                  cmd.len  = count_one_ff;
               end else begin
                  cmd.status = ST_EMPTY;
               end
            end
            OP_LIST_TWO: begin
               cmd_push = 1'b1;
               if (count_two_ff != '0) begin
                  cmd.kind = CMD_LIST;
                  cmd.addr = ADDR_W'(size_ff - CNT_W'(1));
                  cmd.len  = count_two_ff;
                  cmd.down = 1'b1;
               end else begin
                  cmd.status = ST_EMPTY;
               end
            end
            default: begin
               // undefined op codes are dropped without a result
               cmd_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_RESET;
         count_one_ff <= '0;
         count_two_ff <= '0;
      end else begin
         size_ff      <= size_in;
         count_one_ff <= count_one_in;
         count_two_ff <= count_two_in;
      end
   end

endmodule

FILE: rtl/core/tss_back.sv
// Back end: carries out queued commands against the shared RAM and
// drives the result ports. Depends on tss_pkg and tss_ram.
module tss_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   input  tss_pkg::cmd_type               head,
   output logic                           cmd_pop,
   output logic                           rsp_strobe,
   output logic [tss_pkg::STATUS_W-1:0]   rsp_status,
   output logic signed [tss_pkg::VALUE_W-1:0] rsp_data_out,
   output logic                           rsp_last
);
   import tss_pkg::*;

   back_state_type state_ff, state_in;
   addr_type       addr_ff, addr_in;
   count_type      remain_ff, remain_in;
   logic           down_ff, down_in;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_read_ff, rsp_read_in;

   logic     ram_we;
   addr_type ram_raddr;
   word_type ram_rdata;

   tss_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (head.addr),
      .wr_data (head.data),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Issue: at most one memory access per cycle, lists walk the stack
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      remain_in     = remain_ff;
      down_in       = down_ff;
      cmd_pop       = 1'b0;
      ram_we        = 1'b0;
      ram_raddr     = head.addr;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_last_in   = 1'b1;
      rsp_read_in   = 1'b0;

      unique case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop      = 1'b1;
               rsp_valid_in = 1'b1;
               unique case (head.kind)
                  CMD_WRITE: ram_we = 1'b1;
                  CMD_READ:  rsp_read_in = 1'b1;
                  CMD_ERROR: rsp_status_in = head.status;
                  CMD_LIST: begin
                     rsp_read_in = 1'b1;
                     rsp_last_in = (head.len == CNT_W'(1));
                     if (head.len != CNT_W'(1)) begin
                        state_in  = BACK_LIST;
                        addr_in   = head.down ? head.addr - ADDR_W'(1)
                                              : head.addr + ADDR_W'(1);
                        remain_in = head.len - CNT_W'(1);
                        down_in   = head.down;
                     end
                  end
               endcase
            end
         end
         BACK_LIST: begin
            ram_raddr    = addr_ff;
            rsp_valid_in = 1'b1;
            rsp_read_in  = 1'b1;
            rsp_last_in  = (remain_ff == CNT_W'(1));
            addr_in      = down_ff ? addr_ff - ADDR_W'(1) : addr_ff + ADDR_W'(1);
            remain_in    = remain_ff - CNT_W'(1);
            if (remain_ff == CNT_W'(1)) begin
               state_in = BACK_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk position and result payload, no reset needed
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      remain_ff     <= remain_in;
      down_ff       <= down_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_read_ff   <= rsp_read_in;
   end

   // Result ports; read data arrives with the response register
   assign rsp_strobe   = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_data_out = rsp_read_ff ? VALUE_W'(ram_rdata) : '0;

endmodule
